@@ rtl/core/source_whitespace_minifier_assert.svh @@
// ----------------------------------------------------------------------------
// Source whitespace minifier assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_WHITESPACE_MINIFIER_ASSERT_SVH
`define SOURCE_WHITESPACE_MINIFIER_ASSERT_SVH

// same-cycle implication
`define SWM_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swm: same-cycle check failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm: next-cycle check failed");

`endif

@@ rtl/core/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Source whitespace minifier package
// Character codes, the front-to-back command type and classification helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_VT         = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;

  localparam int unsigned FIELD_W     = 32;
  // power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    KIND_TEXT    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic               two_results;
    logic [7:0]         first_byte;
    logic [7:0]         final_byte;
    logic [FIELD_W-1:0] spaces;
    logic [FIELD_W-1:0] blanks;
    logic               closed;
  } cmd_t;

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_hspace(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
           (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/swm_if.sv @@
// ----------------------------------------------------------------------------
// Source whitespace minifier channels
// Valid/ready channels for input text items and for result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface swm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface swm_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        last;
  logic [31:0] spaces_removed;
  logic [31:0] blank_lines_dropped;
  logic        literals_closed;

  modport source (output valid, output kind, output out_byte, output last,
                  output spaces_removed, output blank_lines_dropped,
                  output literals_closed, input ready);
  modport sink   (input valid, input kind, input out_byte, input last,
                  input spaces_removed, input blank_lines_dropped,
                  input literals_closed, output ready);
endinterface

`default_nettype wire

@@ rtl/core/source_whitespace_minifier.sv @@
// ----------------------------------------------------------------------------
// Source whitespace minifier
// Streams C source text, drops redundant whitespace and blank lines, and
// reports removal counts on an end-of-input transaction.
// ----------------------------------------------------------------------------
// Takes one input transaction per cycle while the command queue has room, and
// delivers one result transaction per cycle while the sink is ready. An item
// that re-inserts a space between two words yields two results and holds the
// output register for both; the four-entry command queue between the
// classifying front and the output register absorbs these, so the input stalls
// only when the queue fills. A taken item's command is written into the queue
// and is loaded from there into the output register once that register is free,
// where its result is presented. There is no clearing pass after reset. Counts
// saturate at 2^COUNT_WIDTH - 1 and are reported clipped to 32 bits.
`timescale 1ns / 1ps
`default_nettype none

`include "source_whitespace_minifier_assert.svh"

module source_whitespace_minifier import swm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swm_in_if.sink    in_i,
  swm_out_if.source out_o
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_push_cmd;
  cmd_t q_head;

  swm_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .push_cmd_o (q_push_cmd)
  );

  swm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  swm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (q_head),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  `SWM_ASSERT_IMPLIES(a_no_push_when_full, q_push, !q_full)
  `SWM_ASSERT_IMPLIES(a_no_pop_when_empty, q_pop, !q_empty)
  `SWM_ASSERT_IMPLIES(a_summary_is_last, out_o.valid && out_o.kind, out_o.last && !(|out_o.out_byte))
  `SWM_ASSERT_NEXT(a_second_follows, out_o.valid && out_o.ready && !out_o.last, out_o.valid)

endmodule

`default_nettype wire

@@ rtl/core/swm_queue.sv @@
// ----------------------------------------------------------------------------
// Source whitespace minifier command queue
// Short FIFO of commands between the classifying front and the output back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swm_queue import swm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t                   entry_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/swm_front.sv @@
// ----------------------------------------------------------------------------
// Source whitespace minifier front
// Accepts text items, tracks literal and line state, issues output commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swm_front import swm_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swm_in_if.sink    in_i,
  input  logic      full_i,
  output logic      push_o,
  output cmd_t      push_cmd_o
);

  logic                   in_str_q, in_str_d;
  logic                   in_chr_q, in_chr_d;
  logic                   esc_q, esc_d;
  logic                   sp_pend_q, sp_pend_d;
  logic                   line_has_q, line_has_d;
  logic                   line_start_q, line_start_d;
  logic                   prev_word_q, prev_word_d;
  logic [COUNT_WIDTH-1:0] space_cnt_q, space_cnt_d;
  logic [COUNT_WIDTH-1:0] blank_cnt_q, blank_cnt_d;
  logic [FIELD_W-1:0]     space_clip;
  logic [FIELD_W-1:0]     blank_clip;
  logic                   accept;
  logic                   emit;
  logic                   word;
  logic [7:0]             c;

  generate
    if (COUNT_WIDTH > FIELD_W) begin : g_clip
      assign space_clip = (|space_cnt_q[COUNT_WIDTH-1:FIELD_W]) ? '1
                                                                : space_cnt_q[FIELD_W-1:0];
      assign blank_clip = (|blank_cnt_q[COUNT_WIDTH-1:FIELD_W]) ? '1
                                                                : blank_cnt_q[FIELD_W-1:0];
    end else begin : g_ext
      assign space_clip = FIELD_W'(space_cnt_q);
      assign blank_clip = FIELD_W'(blank_cnt_q);
    end
  endgenerate

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept && emit;
  assign c          = in_i.in_byte;
  assign word       = is_word(c);

  always_comb begin
    in_str_d     = in_str_q;
    in_chr_d     = in_chr_q;
    esc_d        = esc_q;
    sp_pend_d    = sp_pend_q;
    line_has_d   = line_has_q;
    line_start_d = line_start_q;
    prev_word_d  = prev_word_q;
    space_cnt_d  = space_cnt_q;
    blank_cnt_d  = blank_cnt_q;
    emit         = 1'b0;
    push_cmd_o   = '{kind: KIND_TEXT, two_results: 1'b0, first_byte: CH_SPACE,
                     final_byte: c, spaces: '0, blanks: '0, closed: 1'b0};

    if (in_i.end_of_input) begin
      emit                  = 1'b1;
      push_cmd_o.kind       = KIND_SUMMARY;
      push_cmd_o.final_byte = '0;
      push_cmd_o.spaces     = space_clip;
      push_cmd_o.blanks     = blank_clip;
      push_cmd_o.closed     = !(in_str_q || in_chr_q);
      in_str_d              = 1'b0;
      in_chr_d              = 1'b0;
      esc_d                 = 1'b0;
      sp_pend_d             = 1'b0;
      line_has_d            = 1'b0;
      line_start_d          = 1'b1;
      prev_word_d           = 1'b0;
      space_cnt_d           = '0;
      blank_cnt_d           = '0;
    end else if (in_str_q || in_chr_q) begin
      emit = 1'b1;
      if (esc_q) begin
        esc_d = 1'b0;
      end else if (c == CH_BACKSLASH) begin
        esc_d = 1'b1;
      end else if ((in_str_q && c == CH_DQUOTE) || (in_chr_q && c == CH_SQUOTE)) begin
        in_str_d = 1'b0;
        in_chr_d = 1'b0;
      end
      line_has_d   = (c != CH_NEWLINE);
      line_start_d = (c == CH_NEWLINE);
      prev_word_d  = (c != CH_NEWLINE) && word;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      emit         = 1'b1;
      sp_pend_d    = 1'b0;
      line_has_d   = 1'b1;
      line_start_d = 1'b0;
      prev_word_d  = 1'b0;
      in_str_d     = (c == CH_DQUOTE);
      in_chr_d     = (c == CH_SQUOTE);
    end else if (is_hspace(c)) begin
      sp_pend_d   = 1'b1;
      space_cnt_d = (&space_cnt_q) ? space_cnt_q : space_cnt_q + 1'b1;
    end else if (c == CH_NEWLINE) begin
      sp_pend_d = 1'b0;
      if (!line_has_q) begin
        blank_cnt_d = (&blank_cnt_q) ? blank_cnt_q : blank_cnt_q + 1'b1;
      end else begin
        emit       = 1'b1;
        line_has_d = 1'b0;
      end
      line_start_d = 1'b1;
      prev_word_d  = 1'b0;
    end else begin
      emit                   = 1'b1;
      push_cmd_o.two_results = sp_pend_q && !line_start_q && prev_word_q && word;
      sp_pend_d              = 1'b0;
      line_has_d             = 1'b1;
      line_start_d           = 1'b0;
      prev_word_d            = word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_str_q     <= 1'b0;
      in_chr_q     <= 1'b0;
      esc_q        <= 1'b0;
      sp_pend_q    <= 1'b0;
      line_has_q   <= 1'b0;
      line_start_q <= 1'b1;
      prev_word_q  <= 1'b0;
      space_cnt_q  <= '0;
      blank_cnt_q  <= '0;
    end else if (accept) begin
      in_str_q     <= in_str_d;
      in_chr_q     <= in_chr_d;
      esc_q        <= esc_d;
      sp_pend_q    <= sp_pend_d;
      line_has_q   <= line_has_d;
      line_start_q <= line_start_d;
      prev_word_q  <= prev_word_d;
      space_cnt_q  <= space_cnt_d;
      blank_cnt_q  <= blank_cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/swm_back.sv @@
// ----------------------------------------------------------------------------
// Source whitespace minifier back
// Expands queued commands into one or two result transactions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swm_back import swm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  input  cmd_t      head_i,
  output logic      pop_o,
  swm_out_if.source out_o
);

  logic               out_valid_q;
  logic               second_q;
  logic               kind_q;
  logic [7:0]         byte_q;
  logic               last_q;
  logic [FIELD_W-1:0] spaces_q;
  logic [FIELD_W-1:0] blanks_q;
  logic               closed_q;
  logic               load;
  logic               first_half;

  assign load       = !empty_i && (!out_valid_q || out_o.ready);
  assign first_half = head_i.two_results && !second_q;
  assign pop_o      = load && !first_half;

  assign out_o.valid               = out_valid_q;
  assign out_o.kind                = kind_q;
  assign out_o.out_byte            = byte_q;
  assign out_o.last                = last_q;
  assign out_o.spaces_removed      = spaces_q;
  assign out_o.blank_lines_dropped = blanks_q;
  assign out_o.literals_closed     = closed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        second_q    <= first_half;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= logic'(head_i.kind);
      byte_q   <= first_half ? head_i.first_byte : head_i.final_byte;
      last_q   <= !first_half;
      spaces_q <= head_i.spaces;
      blanks_q <= head_i.blanks;
      closed_q <= head_i.closed;
    end
  end

endmodule

`default_nettype wire
